@@ design/dlq_pkg.sv @@
// Shared types, codes and default sizes of the delta-list timer queue.
package dlq_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int ID_W            = 4;
  localparam int NUM_IDS         = 16;
  localparam int SLICE_W         = 16;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [2:0] KIND_WOKEN   = 3'd0;
  localparam logic [2:0] KIND_READY   = 3'd1;
  localparam logic [2:0] KIND_REMOVED = 3'd2;
  localparam logic [2:0] KIND_FAILED  = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] process_id;
    logic [31:0]     sleep_time;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] process_id_out;
    logic [31:0]     return_value;
    logic [2:0]      kind;
    logic            last;
  } out_item_t;

endpackage

@@ design/delta_list_sleep_timer_queue.sv @@
// Top level of the delta-list timer queue: register, sequencer, memory and output stage.
//
// The block keeps sleeping processes in wake-up order, each entry holding only
// the difference from the entry ahead of it. Commands arrive on the input
// channel (in_valid_i / in_ready_o / in_data_i): insert, tick or remove. Every
// result transaction leaves on the output channel (out_valid_o / out_ready_i /
// out_data_o), and the last one caused by a command carries last set.
// The tick slice is written on the configuration channel, which is always
// ready; the user is to write it only while the block is idle, since the
// block itself does not enforce this. One command is worked at a time. The
// list sits in a single-port memory with a registered read port, so a walk
// reads and then checks each entry, and each shift of an entry reads it and
// then writes it to its new slot.
// Reset empties the list, clears every sleeping flag and sets the slice to 10;
// the memory itself is not cleared, since only listed entries are ever read.
// If the receiver stalls, one result waits in the output register while the
// next is held inside; the sequencer then pauses until a slot frees up.
module delta_list_sleep_timer_queue
  import dlq_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [SLICE_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = ID_W + TIME_WIDTH;

  logic [SLICE_W-1:0] slice_q;
  logic               out_valid_q;
  out_item_t          out_q;
  logic               out_free;
  logic               push;
  out_item_t          push_item;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_addr;
  logic [EW-1:0]      mem_wdata, mem_rdata;

  // The slice register takes every configuration transaction at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SLICE_RESET;
    end else if (cfg_valid_i) begin
      slice_q <= cfg_data_i;
    end
  end

  // Output register: free when empty or when its transaction completes now.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= push_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  dlq_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .slice_i    (slice_q),
    .out_free_i (out_free),
    .push_o     (push),
    .push_item_o(push_item),
    .mem_re_o   (mem_re),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  dlq_mem #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(EW)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

@@ design/dlq_mem.sv @@
// Single-port entry memory with a registered read port.
module dlq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 36
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/dlq_ctrl.sv @@
// Sequencer that walks, shifts and updates the delta list held in memory.
module dlq_ctrl
  import dlq_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int EW = ID_W + TIME_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  input  logic [SLICE_W-1:0] slice_i,
  input  logic               out_free_i,
  output logic               push_o,
  output out_item_t          push_item_o,
  output logic               mem_re_o,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_addr_o,
  output logic [EW-1:0]      mem_wdata_o,
  input  logic [EW-1:0]      mem_rdata_i
);

  localparam int TW = TIME_WIDTH;
  localparam int OW = (TW > SLICE_W) ? TW : SLICE_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_WALK_RD   = 4'd1;
  localparam logic [3:0] S_WALK_CHK  = 4'd2;
  localparam logic [3:0] S_SH_RD     = 4'd3;
  localparam logic [3:0] S_SH_WR     = 4'd4;
  localparam logic [3:0] S_INS_START = 4'd5;
  localparam logic [3:0] S_INS_RD    = 4'd6;
  localparam logic [3:0] S_INS_CHK   = 4'd7;
  localparam logic [3:0] S_SU_RD     = 4'd8;
  localparam logic [3:0] S_SU_WR     = 4'd9;
  localparam logic [3:0] S_INS_W1    = 4'd10;
  localparam logic [3:0] S_INS_W0    = 4'd11;
  localparam logic [3:0] S_TICK_RD   = 4'd12;
  localparam logic [3:0] S_TICK_CHK  = 4'd13;
  localparam logic [3:0] S_FIN       = 4'd14;

  localparam logic [1:0] MODE_REMOVE = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE     = CW'(1);

  logic [3:0]       state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [CW-1:0]    idx_q, idx_d, pos_q, pos_d, cnt_q, cnt_d;
  logic             first_q, first_d, has_succ_q, has_succ_d;
  logic [TW-1:0]    add_q, add_d, sum_q, sum_d, t_q, t_d, succ_d_q, succ_d_d;
  logic [OW-1:0]    over_q, over_d;
  logic [ID_W-1:0]  id_q, id_d, succ_id_q, succ_id_d;
  logic [NUM_IDS-1:0] sleep_q, sleep_d;
  logic             pend_valid_q, pend_valid_d;
  out_item_t        pend_q, pend_d;

  logic [ID_W-1:0]  rid;
  logic [TW-1:0]    rd;
  logic [OW-1:0]    rd_ext;
  logic [CW-1:0]    idx_inc;
  logic [TW+31:0]   sum_ext;
  logic [TW+31:0]   st_ext;

  assign rid     = mem_rdata_i[EW-1:TW];
  assign rd      = mem_rdata_i[TW-1:0];
  assign rd_ext  = OW'(rd);
  assign idx_inc = idx_q + ONE;
  assign sum_ext = {32'd0, sum_q};
  assign st_ext  = {{TW{1'b0}}, in_data_i.sleep_time};

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    first_d      = first_q;
    has_succ_d   = has_succ_q;
    add_d        = add_q;
    sum_d        = sum_q;
    t_d          = t_q;
    succ_d_d     = succ_d_q;
    succ_id_d    = succ_id_q;
    over_d       = over_q;
    id_d         = id_q;
    sleep_d      = sleep_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    in_ready_o   = 1'b0;
    push_o       = 1'b0;
    push_item_o  = pend_q;
    mem_re_o     = 1'b0;
    mem_we_o     = 1'b0;
    mem_addr_o   = idx_q[AW-1:0];
    mem_wdata_o  = mem_rdata_i;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          id_d  = in_data_i.process_id;
          t_d   = st_ext[TW-1:0];
          idx_d = '0;
          sum_d = '0;
          case (in_data_i.action)
            ACT_INSERT: begin
              if (sleep_q[in_data_i.process_id]) begin
                mode_d  = MODE_INSERT;
                state_d = S_WALK_RD;
              end else begin
                state_d = S_INS_START;
              end
            end
            ACT_TICK: begin
              if (cnt_q != '0) begin
                over_d  = OW'(slice_i);
                state_d = S_TICK_RD;
              end
            end
            ACT_REMOVE: begin
              if (sleep_q[in_data_i.process_id]) begin
                mode_d  = MODE_REMOVE;
                state_d = S_WALK_RD;
              end else begin
                pend_valid_d = 1'b1;
                pend_d = '{process_id_out: in_data_i.process_id, return_value: 32'd0,
                           kind: KIND_FAILED, last: 1'b0};
                state_d = S_FIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK_RD: begin
        mem_re_o = 1'b1;
        state_d  = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        sum_d = sum_q + rd;
        if (rid == id_q) begin
          add_d          = rd;
          first_d        = 1'b1;
          sleep_d[id_q]  = 1'b0;
          state_d        = S_SH_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_WALK_RD;
        end
      end
      S_SH_RD: begin
        if (idx_inc < cnt_q) begin
          mem_re_o   = 1'b1;
          mem_addr_o = idx_inc[AW-1:0];
          state_d    = S_SH_WR;
        end else begin
          cnt_d = cnt_q - ONE;
          case (mode_q)
            MODE_REMOVE: begin
              pend_valid_d = 1'b1;
              pend_d = '{process_id_out: id_q, return_value: sum_ext[31:0],
                         kind: KIND_REMOVED, last: 1'b0};
              state_d = S_FIN;
            end
            MODE_INSERT: state_d = S_INS_START;
            default:     state_d = S_TICK_RD;
          endcase
        end
      end
      S_SH_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {rid, rd + (first_q ? add_q : '0)};
        first_d     = 1'b0;
        idx_d       = idx_inc;
        state_d     = S_SH_RD;
      end
      S_INS_START: begin
        idx_d = '0;
        if (t_q == '0) begin
          pend_valid_d = 1'b1;
          pend_d = '{process_id_out: id_q, return_value: 32'd0,
                     kind: KIND_READY, last: 1'b0};
          state_d = S_FIN;
        end else if (cnt_q >= CNT_MAX) begin
          pend_valid_d = 1'b1;
          pend_d = '{process_id_out: id_q, return_value: 32'd0,
                     kind: KIND_FULL, last: 1'b0};
          state_d = S_FIN;
        end else begin
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (idx_q < cnt_q) begin
          mem_re_o = 1'b1;
          state_d  = S_INS_CHK;
        end else begin
          pos_d      = idx_q;
          has_succ_d = 1'b0;
          idx_d      = cnt_q;
          state_d    = S_SU_RD;
        end
      end
      S_INS_CHK: begin
        if (rd <= t_q) begin
          t_d     = t_q - rd;
          idx_d   = idx_inc;
          state_d = S_INS_RD;
        end else begin
          succ_id_d  = rid;
          succ_d_d   = rd - t_q;
          has_succ_d = 1'b1;
          pos_d      = idx_q;
          idx_d      = cnt_q;
          state_d    = S_SU_RD;
        end
      end
      S_SU_RD: begin
        if (idx_q > pos_q + CW'(has_succ_q)) begin
          mem_re_o   = 1'b1;
          mem_addr_o = AW'(idx_q - ONE);
          state_d    = S_SU_WR;
        end else begin
          state_d = has_succ_q ? S_INS_W1 : S_INS_W0;
        end
      end
      S_SU_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = mem_rdata_i;
        idx_d       = idx_q - ONE;
        state_d     = S_SU_RD;
      end
      S_INS_W1: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = AW'(pos_q + ONE);
        mem_wdata_o = {succ_id_q, succ_d_q};
        state_d     = S_INS_W0;
      end
      S_INS_W0: begin
        mem_we_o      = 1'b1;
        mem_addr_o    = pos_q[AW-1:0];
        mem_wdata_o   = {id_q, t_q};
        cnt_d         = cnt_q + ONE;
        sleep_d[id_q] = 1'b1;
        state_d       = S_IDLE;
      end
      S_TICK_RD: begin
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          mem_re_o   = 1'b1;
          mem_addr_o = '0;
          state_d    = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        if (rd_ext > over_q) begin
          // Head survives this tick; whatever is left of the slice comes off it.
          mem_we_o    = 1'b1;
          mem_addr_o  = '0;
          mem_wdata_o = {rid, rd - over_q[TW-1:0]};
          state_d     = S_FIN;
        end else if (!(pend_valid_q && !out_free_i)) begin
          push_o       = pend_valid_q;
          pend_valid_d = 1'b1;
          pend_d = '{process_id_out: rid, return_value: 32'd0,
                     kind: KIND_WOKEN, last: 1'b0};
          sleep_d[rid] = 1'b0;
          over_d       = over_q - rd_ext;
          idx_d        = '0;
          first_d      = 1'b1;
          add_d        = '0;
          mode_d       = MODE_TICK;
          state_d      = S_SH_RD;
        end
      end
      S_FIN: begin
        push_item_o.last = 1'b1;
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free_i) begin
          push_o       = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      sleep_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      sleep_q      <= sleep_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    first_q    <= first_d;
    has_succ_q <= has_succ_d;
    add_q      <= add_d;
    sum_q      <= sum_d;
    t_q        <= t_d;
    succ_d_q   <= succ_d_d;
    succ_id_q  <= succ_id_d;
    over_q     <= over_d;
    id_q       <= id_d;
    pend_q     <= pend_d;
  end

endmodule
